// ===== rtl/csvp_pkg.sv =====
// ----------------------------------------------------------------------------
// csvp_pkg
// Types and constants shared by the CSV line field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package csvp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 8;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_DELIMITER = 8'd0;
    localparam logic [IDX_W-1:0] REG_QUOTE     = 8'd1;

    localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_RESET     = 8'd34;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              line_end;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] field_byte;
        logic              byte_valid;
        logic              field_done;
        logic              line_done;
        logic              last_of_run;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic [BYTE_W-1:0] delimiter_char;
        logic [BYTE_W-1:0] quote_byte;
    } cfg_t;

    // results of one item, handed from the parser to the result buffer
    typedef struct packed {
        logic       valid;
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // result buffer status seen by the parser
    typedef struct packed {
        logic can_take;
    } buf_status_t;

endpackage

`default_nettype wire

// ===== rtl/csvp_stream_if.sv =====
// ----------------------------------------------------------------------------
// csvp_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvp_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/csvp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// csvp_cfg_regs
// Delimiter and quote character registers behind the write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module csvp_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    csvp_stream_if.sink        cfg,
    output csvp_pkg::cfg_t     regs
);

    logic [csvp_pkg::BYTE_W-1:0] delimiter_reg;
    logic [csvp_pkg::BYTE_W-1:0] quote_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= csvp_pkg::DELIMITER_RESET;
            quote_reg     <= csvp_pkg::QUOTE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                csvp_pkg::REG_DELIMITER: delimiter_reg <= cfg.data.value;
                csvp_pkg::REG_QUOTE:     quote_reg     <= cfg.data.value;
                default: ;
            endcase
        end
    end

    assign regs.delimiter_char = delimiter_reg;
    assign regs.quote_byte     = quote_reg;

endmodule

`default_nettype wire

// ===== rtl/csvp_parse_core.sv =====
// ----------------------------------------------------------------------------
// csvp_parse_core
// Input register, quote/delimiter decode and the per-line parser state.
// ----------------------------------------------------------------------------
`default_nettype none

module csvp_parse_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    csvp_stream_if.sink                item,
    input  wire csvp_pkg::cfg_t        regs,
    input  wire csvp_pkg::buf_status_t buf_status,
    output csvp_pkg::push_t            push
);

    csvp_pkg::item_t item_reg;
    logic            item_valid_reg;
    logic            quoted_mode_reg;
    logic            quote_pending_reg;
    logic            line_started_reg;

    logic            quoted_mode_next;
    logic            quote_pending_next;
    logic            line_started_next;

    logic            take;
    logic            first_hit;
    logic            line_hit;
    csvp_pkg::result_t first_res;
    csvp_pkg::result_t line_res;
    logic            advance;

    always_comb
    begin
        quoted_mode_next   = quoted_mode_reg;
        quote_pending_next = quote_pending_reg;
        line_started_next  = line_started_reg;
        take               = 1'b0;
        first_hit          = 1'b0;
        line_hit           = 1'b0;
        first_res          = '0;
        line_res           = '0;

        if (item_reg.has_byte)
        begin
            line_started_next = 1'b1;
            take              = 1'b1;
            if (quote_pending_reg)
            begin
                quote_pending_next = 1'b0;
                if (item_reg.data_byte == regs.quote_byte)
                begin
                    // doubled quote: one literal quote byte
                    first_hit            = 1'b1;
                    first_res.field_byte = item_reg.data_byte;
                    first_res.byte_valid = 1'b1;
                    take                 = 1'b0;
                end
                else
                begin
                    quoted_mode_next = 1'b0;
                end
            end
            if (take)
            begin
                if (item_reg.data_byte == regs.quote_byte)
                begin
                    if (quoted_mode_next && !item_reg.line_end)
                        quote_pending_next = 1'b1;
                    else
                        quoted_mode_next = !quoted_mode_next;
                end
                else if (item_reg.data_byte == regs.delimiter_char && !quoted_mode_next)
                begin
                    first_hit            = 1'b1;
                    first_res.field_done = 1'b1;
                end
                else
                begin
                    first_hit            = 1'b1;
                    first_res.field_byte = item_reg.data_byte;
                    first_res.byte_valid = 1'b1;
                end
            end
        end

        if (item_reg.line_end)
        begin
            // empty line gives nothing
            line_hit           = line_started_next;
            line_res.field_done = 1'b1;
            line_res.line_done  = 1'b1;
            quoted_mode_next   = 1'b0;
            quote_pending_next = 1'b0;
            line_started_next  = 1'b0;
        end

        first_res.last_of_run = !line_hit;
        line_res.last_of_run  = 1'b1;
    end

    assign advance    = item_valid_reg && buf_status.can_take;
    assign item.ready = !item_valid_reg || advance;

    always_comb
    begin
        push.valid = advance && (first_hit || line_hit);
        push.count = {1'b0, first_hit} + {1'b0, line_hit};
        if (first_hit)
        begin
            push.first  = first_res;
            push.second = line_res;
        end
        else
        begin
            push.first  = line_res;
            push.second = line_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            quoted_mode_reg   <= 1'b0;
            quote_pending_reg <= 1'b0;
            line_started_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
                item_valid_reg <= item.valid;
            if (advance)
            begin
                quoted_mode_reg   <= quoted_mode_next;
                quote_pending_reg <= quote_pending_next;
                line_started_reg  <= line_started_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            item_reg <= item.data;
    end

    // a held quote only exists inside quotes
    assert property (@(posedge clk) disable iff (!rst_n)
        quote_pending_reg |-> quoted_mode_reg)
        else $error("quote held back outside quoted mode");

    // a line end leaves the parser clean
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.line_end) |=>
            (!quoted_mode_reg && !quote_pending_reg && !line_started_reg))
        else $error("parser state not cleared after line end");

endmodule

`default_nettype wire

// ===== rtl/csvp_out_buf.sv =====
// ----------------------------------------------------------------------------
// csvp_out_buf
// Two-entry result buffer; sends the results of one item one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module csvp_out_buf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire csvp_pkg::push_t     push,
    output csvp_pkg::buf_status_t    buf_status,
    csvp_stream_if.source            result
);

    csvp_pkg::result_t head_reg;
    csvp_pkg::result_t tail_reg;
    logic [1:0]        cnt_reg;
    logic              pop;

    assign result.valid        = (cnt_reg != 2'd0);
    assign result.data         = head_reg;
    assign pop                 = result.valid && result.ready;
    assign buf_status.can_take = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (push.valid)
            cnt_reg <= push.count;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            head_reg <= push.first;
            tail_reg <= push.second;
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer overfilled");

    // results are only loaded once the buffer has drained
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> buf_status.can_take)
        else $error("push into busy result buffer");

endmodule

`default_nettype wire

// ===== rtl/csv_line_field_parser.sv =====
// ----------------------------------------------------------------------------
// csv_line_field_parser
// Streaming CSV field splitter for one newline-stripped line at a time.
// ----------------------------------------------------------------------------
//  channel  dir  payload       beat
//  cfg      in   cfg_write_t   one register write (index, value)
//  item     in   item_t        one line byte and/or line-end marker
//  result   out  result_t      one content byte, field end or line end
//
//  An item is taken every cycle while the result buffer can take it; each
//  item passes the input register, then the result buffer. An item that
//  yields both a byte/field result and a line end needs two result beats, so
//  the next item waits until the result buffer has sent both. A stalled
//  result side holds the buffer and then the input register. Reset clears
//  the parser state and loads delimiter ',' and quote '"'.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_line_field_parser (
    input  wire logic     clk,
    input  wire logic     rst_n,
    csvp_stream_if.sink   cfg,
    csvp_stream_if.sink   item,
    csvp_stream_if.source result
);

    csvp_pkg::cfg_t        regs;
    csvp_pkg::push_t       push;
    csvp_pkg::buf_status_t buf_status;

    csvp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    csvp_parse_core u_parse_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .regs       (regs),
        .buf_status (buf_status),
        .push       (push)
    );

    csvp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .buf_status (buf_status),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== test/tb_csv_line_field_parser.sv =====
// ----------------------------------------------------------------------------
// tb_csv_line_field_parser
// Self-checking bench for the CSV line field parser. A directed table runs
// first at reset settings. Random lines follow under several delimiter and
// quote settings: well-formed fields, quoted fields with doubled quotes, and
// some noise. Each result beat is checked against typed or predicted beats.
// ----------------------------------------------------------------------------
module tb_csv_line_field_parser;

    localparam logic [csvp_pkg::IDX_W-1:0]  REG_UNUSED   = 8'hFF;
    localparam logic [csvp_pkg::BYTE_W-1:0] CH_COMMA     = csvp_pkg::DELIMITER_RESET;
    localparam logic [csvp_pkg::BYTE_W-1:0] CH_QUOTE     = csvp_pkg::QUOTE_RESET;
    localparam int                SETTLE_CYCLES = 6;
    localparam int                HOLD_CYCLES   = 40;
    localparam int                IDLE_LIMIT    = 500;
    localparam int                PHASE_ITEMS   = 16;

    typedef struct {
        csvp_pkg::item_t   it;
        int                n_typed;   // -1: take the predictor's beats
        csvp_pkg::result_t t0;
        csvp_pkg::result_t t1;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    csvp_stream_if #(.payload_t(csvp_pkg::cfg_write_t)) cfg_ch ();
    csvp_stream_if #(.payload_t(csvp_pkg::item_t))      item_ch ();
    csvp_stream_if #(.payload_t(csvp_pkg::result_t))    result_ch ();

    csv_line_field_parser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state and register copy
    logic [csvp_pkg::BYTE_W-1:0] p_delim  = csvp_pkg::DELIMITER_RESET;
    logic [csvp_pkg::BYTE_W-1:0] p_quote  = csvp_pkg::QUOTE_RESET;
    logic              p_quoted = 1'b0;
    logic              p_held   = 1'b0;
    logic              p_started = 1'b0;

    csvp_pkg::result_t expected_beats[$];
    row_t    dir_rows[$];
    int      mismatches = 0;
    int      items_sent = 0;
    bit      src_quiet  = 1'b0;
    bit      snk_quiet  = 1'b0;
    bit      burst      = 1'b0;
    bit      long_hold  = 1'b0;

    function automatic csvp_pkg::result_t mk_beat(logic [csvp_pkg::BYTE_W-1:0] b, logic bv,
                                                  logic fd, logic ld, logic last);
        csvp_pkg::result_t r;
        r.field_byte  = bv ? b : '0;
        r.byte_valid  = bv;
        r.field_done  = fd;
        r.line_done   = ld;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic csvp_pkg::item_t mk_item(logic [csvp_pkg::BYTE_W-1:0] b, logic has,
                                                logic lend);
        csvp_pkg::item_t it;
        it.data_byte = b;
        it.has_byte  = has;
        it.line_end  = lend;
        return it;
    endfunction

    function automatic void add_row(logic [csvp_pkg::BYTE_W-1:0] b, logic has, logic lend,
                                    int n, csvp_pkg::result_t t0, csvp_pkg::result_t t1);
        row_t r;
        r.it      = mk_item(b, has, lend);
        r.n_typed = n;
        r.t0      = t0;
        r.t1      = t1;
        dir_rows  = {dir_rows, r};
    endfunction

    // splits one item into content, field-end and line-end beats
    function automatic void parse_item(input csvp_pkg::item_t it,
                                       output csvp_pkg::result_t beats[3], output int n);
        logic [csvp_pkg::BYTE_W-1:0] b;
        b = it.data_byte;
        n = 0;
        if (it.has_byte)
        begin
            p_started = 1'b1;
            if (p_held && b == p_quote)
            begin
                // doubled quote inside quotes: one literal quote
                p_held   = 1'b0;
                beats[n] = mk_beat(b, 1'b1, 1'b0, 1'b0, 1'b0);
                n++;
            end
            else
            begin
                if (p_held)
                begin
                    p_held   = 1'b0;
                    p_quoted = 1'b0;
                end
                if (b == p_quote)
                begin
                    if (p_quoted && !it.line_end)
                        p_held = 1'b1;
                    else
                        p_quoted = !p_quoted;
                end
                else if (b == p_delim && !p_quoted)
                begin
                    beats[n] = mk_beat('0, 1'b0, 1'b1, 1'b0, 1'b0);
                    n++;
                end
                else
                begin
                    beats[n] = mk_beat(b, 1'b1, 1'b0, 1'b0, 1'b0);
                    n++;
                end
            end
        end
        if (it.line_end)
        begin
            if (p_started)
            begin
                beats[n] = mk_beat('0, 1'b0, 1'b1, 1'b1, 1'b0);
                n++;
            end
            p_quoted  = 1'b0;
            p_held    = 1'b0;
            p_started = 1'b0;
        end
        if (n > 0)
            beats[n-1].last_of_run = 1'b1;
    endfunction

    function automatic void check_beat(csvp_pkg::result_t got);
        csvp_pkg::result_t want;
        if (expected_beats.size() == 0)
        begin
            $error("result beat with nothing expected: %p", got);
            mismatches++;
            return;
        end
        want = expected_beats.pop_front();
        if (got.field_byte !== want.field_byte)
        begin
            $error("field_byte: expected %0h, got %0h", want.field_byte, got.field_byte);
            mismatches++;
        end
        if (got.byte_valid !== want.byte_valid)
        begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
            mismatches++;
        end
        if (got.field_done !== want.field_done)
        begin
            $error("field_done: expected %0b, got %0b", want.field_done, got.field_done);
            mismatches++;
        end
        if (got.line_done !== want.line_done)
        begin
            $error("line_done: expected %0b, got %0b", want.line_done, got.line_done);
            mismatches++;
        end
        if (got.last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            mismatches++;
        end
    endfunction

    // valid stays high across back-to-back beats
    task automatic send_item(csvp_pkg::item_t it, int n_typed, csvp_pkg::result_t t0,
                             csvp_pkg::result_t t1);
        csvp_pkg::result_t beats[3];
        int      n;
        int      gap;
        if (items_sent % 16 == 0)
            src_quiet = ($urandom_range(0, 3) == 0);
        gap = (src_quiet || burst) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
        parse_item(it, beats, n);
        if (n_typed >= 0)
        begin
            n        = n_typed;
            beats[0] = t0;
            beats[1] = t1;
        end
        for (int i = 0; i < n; i++)
            expected_beats = {expected_beats, beats[i]};
    endtask

    task automatic cfg_beat(logic [csvp_pkg::IDX_W-1:0] idx,
                            logic [csvp_pkg::BYTE_W-1:0] val);
        csvp_pkg::cfg_write_t w;
        w.index = idx;
        w.value = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            csvp_pkg::REG_DELIMITER: p_delim = val;
            csvp_pkg::REG_QUOTE:     p_quote = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [csvp_pkg::BYTE_W-1:0] delim,
                                logic [csvp_pkg::BYTE_W-1:0] quote);
        cfg_beat(csvp_pkg::REG_DELIMITER, delim);
        cfg_beat(csvp_pkg::REG_QUOTE, quote);
        cfg_ch.valid <= 1'b0;
    endtask

    // hold the input until every expected beat is out and the pipe is empty
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_line();
        csvp_pkg::item_t line_q[$];
        int    n_fields;
        int    k;
        n_fields = $urandom_range(0, 4);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f > 0)
                line_q = {line_q, mk_item(p_delim, 1'b1, 1'b0)};
            k = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0, 1:
                    repeat (k) line_q = {line_q, mk_item(8'($urandom_range(0, 255)), 1'b1,
                                                         1'b0)};
                2:
                begin
                    line_q = {line_q, mk_item(p_quote, 1'b1, 1'b0)};
                    repeat (k)
                    begin
                        case ($urandom_range(0, 4))
                            0:
                            begin
                                line_q = {line_q, mk_item(p_quote, 1'b1, 1'b0)};
                                line_q = {line_q, mk_item(p_quote, 1'b1, 1'b0)};
                            end
                            1: line_q = {line_q, mk_item(p_delim, 1'b1, 1'b0)};
                            default:
                                line_q = {line_q, mk_item(8'($urandom_range(0, 255)), 1'b1,
                                                          1'b0)};
                        endcase
                    end
                    // sometimes the quote is left open
                    if ($urandom_range(0, 4) != 0)
                        line_q = {line_q, mk_item(p_quote, 1'b1, 1'b0)};
                end
                default:
                    repeat (k) line_q = {line_q, mk_item(8'($urandom_range(0, 255)),
                                                         1'($urandom_range(0, 1)), 1'b0)};
            endcase
        end
        if (line_q.size() == 0 || $urandom_range(0, 1) == 0)
            line_q = {line_q, mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1)};
        else
            line_q[line_q.size()-1].line_end = 1'b1;
        foreach (line_q[i])
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0), -1, '0, '0);
            send_item(line_q[i], -1, '0, '0);
        end
    endtask

    // result side: random stalls, quiet stretches, one long hold-off on request
    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        forever
        begin
            if (taken % 16 == 0)
                snk_quiet = ($urandom_range(0, 3) == 0);
            stall = snk_quiet ? 0 : $urandom_range(0, 9);
            if (long_hold)
            begin
                stall     = HOLD_CYCLES;
                long_hold = 1'b0;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            check_beat(result_ch.data);
            taken++;
        end
    end

    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[csv_line_field_parser] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [csvp_pkg::BYTE_W-1:0] d;
        logic [csvp_pkg::BYTE_W-1:0] q;
        int                target;
        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;

        // reset settings: ',' delimiter, '"' quote
        add_row(8'h00, 1'b0, 1'b1, 0, '0, '0);              // empty line
        add_row(8'h00, 1'b1, 1'b0, 1, mk_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b1), '0);
        add_row(8'hFF, 1'b1, 1'b0, 1, mk_beat(8'hFF, 1'b1, 1'b0, 1'b0, 1'b1), '0);
        add_row(CH_COMMA, 1'b1, 1'b0, 1, mk_beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b1), '0);
        add_row(8'hA5, 1'b0, 1'b1, 1, mk_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1), '0);
        add_row(8'h61, 1'b1, 1'b1, 2, mk_beat(8'h61, 1'b1, 1'b0, 1'b0, 1'b0),
                mk_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        add_row(CH_COMMA, 1'b1, 1'b1, 2, mk_beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b0),
                mk_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        add_row(8'h5A, 1'b0, 1'b0, 0, '0, '0);              // bare item, ignored
        add_row(CH_QUOTE, 1'b1, 1'b0, -1, '0, '0);          // open quotes
        add_row(CH_COMMA, 1'b1, 1'b0, -1, '0, '0);          // delimiter as content
        add_row(CH_QUOTE, 1'b1, 1'b0, -1, '0, '0);          // quote held
        add_row(8'hFF, 1'b0, 1'b0, -1, '0, '0);             // bare item keeps it held
        add_row(CH_QUOTE, 1'b1, 1'b0, -1, '0, '0);          // doubled: literal quote
        add_row(CH_QUOTE, 1'b1, 1'b0, -1, '0, '0);
        add_row(CH_COMMA, 1'b1, 1'b0, -1, '0, '0);          // closes, then ends field
        add_row(8'h62, 1'b1, 1'b0, -1, '0, '0);
        add_row(CH_QUOTE, 1'b1, 1'b0, -1, '0, '0);          // quote mid-field opens
        add_row(CH_QUOTE, 1'b1, 1'b0, -1, '0, '0);
        add_row(8'h00, 1'b0, 1'b1, -1, '0, '0);             // line end with quote held
        add_row(CH_QUOTE, 1'b1, 1'b0, -1, '0, '0);
        add_row(CH_QUOTE, 1'b1, 1'b1, -1, '0, '0);          // closing quote on line end
        add_row(CH_QUOTE, 1'b1, 1'b0, -1, '0, '0);
        add_row(8'h63, 1'b1, 1'b1, -1, '0, '0);             // line ends inside quotes
        add_row(CH_QUOTE, 1'b1, 1'b1, -1, '0, '0);          // lone quote line

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].n_typed, dir_rows[i].t0, dir_rows[i].t1);

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            case (ph)
                0: begin d = 8'h00; q = 8'hFF; end
                1: begin d = 8'hFF; q = 8'h00; end
                2: begin d = 8'h7C; q = 8'h7C; end     // quote wins over delimiter
                3: begin d = 8'($urandom_range(0, 255)); q = 8'($urandom_range(0, 255)); end
                default: begin d = csvp_pkg::DELIMITER_RESET; q = csvp_pkg::QUOTE_RESET; end
            endcase
            if (ph == 0)
                cfg_beat(REG_UNUSED, 8'($urandom_range(0, 255)));
            program_regs(d, q);
            target = items_sent + PHASE_ITEMS;
            if (ph == 1)
            begin
                // result side holds off while items keep coming
                long_hold = 1'b1;
                burst     = 1'b1;
                repeat (12) send_item(mk_item(8'($urandom_range(1, 254)), 1'b1, 1'b0),
                                      -1, '0, '0);
                burst = 1'b0;
            end
            while (items_sent < target)
            begin
                send_random_line();
                if (ph == 2 && items_sent >= target - PHASE_ITEMS / 2 && !burst)
                begin
                    drain();
                    burst = 1'b1;
                    send_random_line();
                    burst = 1'b0;
                end
            end
        end

        drain();
        if (mismatches == 0)
            $display("[csv_line_field_parser] OK");
        else
            $display("[csv_line_field_parser] ERROR");
        $finish;
    end

endmodule
